@@ hdl/mxkd_pkg.sv @@
// Package for the modular exponentiation key derivation block.
// Holds word widths, register indexes, reset values and the sequencer state type.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package mxkd_pkg;

    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 1'b1;

    // Register values after reset.
    localparam logic [WORD_W-1:0] MODULUS_RESET   = 32'd2147483645;
    localparam logic [WORD_W-1:0] GENERATOR_RESET = 32'd2147483647;

    // Operation codes carried by an input beat.
    localparam logic OP_GENERATOR = 1'b0;
    localparam logic OP_PEER      = 1'b1;

    // Steps of one modular multiply: one multiplier bit per cycle.
    localparam int MUL_STEPS = WORD_W;
    localparam int STEP_W    = $clog2(MUL_STEPS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_NEXT = 6'b000100,
        S_MUL  = 6'b001000,
        S_SQR  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

endpackage

@@ hdl/mxkd_in_if.sv @@
// Input channel of the key derivation block: operation, peer value and exponent.
// Depends on mxkd_pkg for the word width.
`timescale 1ns / 1ps

interface mxkd_in_if
    import mxkd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [WORD_W-1:0] peer_value;
    logic [WORD_W-1:0] exponent;

    modport source (output valid, output operation, output peer_value, output exponent,
                    input ready);
    modport sink   (input valid, input operation, input peer_value, input exponent,
                    output ready);
endinterface

@@ hdl/mxkd_out_if.sv @@
// Output channel of the key derivation block: the derived key value.
// Depends on mxkd_pkg for the word width.
`timescale 1ns / 1ps

interface mxkd_out_if
    import mxkd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] key_value;

    modport source (output valid, output key_value, input ready);
    modport sink   (input valid, input key_value, output ready);
endinterface

@@ hdl/modular_exponentiation_key_derive_top.sv @@
// Top level of the modular exponentiation key derivation block.
// Depends on mxkd_pkg, mxkd_in_if and mxkd_out_if.
`timescale 1ns / 1ps

// Usage
// Each input beat carries an operation, a peer value and an exponent. Operation zero
// raises the configured generator to the exponent, operation one raises the peer
// value; the result beat carries base ^ exponent mod modulus. A modulus of zero or
// one gives a result of zero without any arithmetic. The modulus and generator are
// written through the plain write port (index 0 and index 1); there is no read-back.
// The user must write them only while idle; the block itself does not enforce this.
// Arithmetic: one shared modular multiplier does all the work, one multiplier bit per
// cycle, and each later multiply is set up in the dispatch state. An item costs a
// reduction of the base, one squaring per exponent bit except the last, and one
// multiply per set exponent bit. The input is ready again once the result is loaded
// into the output register.
// Flow: one item at a time; the input is ready only while the sequencer idles.
// A finished result sits in the output register, so a new item can be taken while
// the receiver stalls; the following result then waits in its final state until the
// output register is empty or being read.
// Reset clears the sequencer and the output valid, and restores the register values.
module modular_exponentiation_key_derive_top
    import mxkd_pkg::*;
#(
    parameter int EXP_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    mxkd_in_if.sink              i_in,
    mxkd_out_if.source           o_out
);

    localparam int LEFT_W = $clog2(EXP_BITS + 1);

    t_state              r_state;
    logic [WORD_W-1:0]   r_mod;
    logic [WORD_W-1:0]   r_gen;
    logic [WORD_W-1:0]   r_acc;
    logic [WORD_W-1:0]   r_sq;
    logic [EXP_BITS-1:0] r_exp;
    logic [LEFT_W-1:0]   r_left;
    logic                r_mul_done;
    logic [WORD_W-1:0]   r_a;
    logic [WORD_W-1:0]   r_b;
    logic [WORD_W-1:0]   r_r;
    logic [STEP_W-1:0]   r_cnt;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_data;

    logic                in_accept;
    logic                out_free;
    logic                step_last;
    logic [WORD_W-1:0]   base;
    logic [WORD_W+1:0]   mul_sum;
    logic [WORD_W+2:0]   mul_sub1;
    logic [WORD_W+2:0]   mul_sub2;
    logic [WORD_W-1:0]   n_r;

    assign i_in.ready      = (r_state == S_IDLE);
    assign in_accept       = i_in.valid && i_in.ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.key_value = r_out_data;
    assign out_free        = !r_out_valid || o_out.ready;
    assign step_last       = (r_cnt == STEP_W'(MUL_STEPS - 1));
    assign base            = (i_in.operation == OP_PEER) ? i_in.peer_value : r_gen;

    // Shared multiplier step: r = 2r + (bit ? a : 0), then reduced. With r and a both
    // below the modulus the sum stays below three times it, so subtracting either
    // once or twice the modulus, chosen in parallel, brings it back into range.
    always_comb begin
        mul_sum  = {1'b0, r_r, 1'b0} + (r_b[WORD_W-1] ? {2'b00, r_a} : '0);
        mul_sub1 = {1'b0, mul_sum} - {3'b000, r_mod};
        mul_sub2 = {1'b0, mul_sum} - {2'b00, r_mod, 1'b0};
        if (!mul_sub2[WORD_W+2]) begin
            n_r = mul_sub2[WORD_W-1:0];
        end else if (!mul_sub1[WORD_W+2]) begin
            n_r = mul_sub1[WORD_W-1:0];
        end else begin
            n_r = mul_sum[WORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mod       <= MODULUS_RESET;
            r_gen       <= GENERATOR_RESET;
            r_out_valid <= 1'b0;
            r_mul_done  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MODULUS:   r_mod <= i_cfg_data;
                    CFG_GENERATOR: r_gen <= i_cfg_data;
                    default: ;
                endcase
            end

            // A waiting result reloads the output register itself in the same cycle.
            if (r_out_valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            // The multiplier runs whenever the sequencer sits in a multiply state.
            if (r_state == S_RED || r_state == S_MUL || r_state == S_SQR) begin
                r_r   <= n_r;
                r_b   <= r_b << 1;
                r_cnt <= r_cnt + STEP_W'(1);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_exp      <= i_in.exponent[EXP_BITS-1:0];
                        r_left     <= LEFT_W'(EXP_BITS);
                        r_mul_done <= 1'b0;
                        if (r_mod <= WORD_W'(1)) begin
                            // Every residue modulo zero or one is taken as zero.
                            r_acc   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            // Reduce the base as 1 * base mod m.
                            r_acc   <= WORD_W'(1);
                            r_a     <= WORD_W'(1);
                            r_b     <= base;
                            r_r     <= '0;
                            r_cnt   <= '0;
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (step_last) begin
                        r_sq    <= n_r;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_r   <= '0;
                    r_cnt <= '0;
                    if (r_exp[0] && !r_mul_done) begin
                        r_a     <= r_acc;
                        r_b     <= r_sq;
                        r_state <= S_MUL;
                    end else if (r_left == LEFT_W'(1)) begin
                        // The square after the top exponent bit is never used.
                        r_state <= S_DONE;
                    end else begin
                        r_a     <= r_sq;
                        r_b     <= r_sq;
                        r_state <= S_SQR;
                    end
                end
                S_MUL: begin
                    if (step_last) begin
                        r_acc      <= n_r;
                        r_mul_done <= 1'b1;
                        r_state    <= S_NEXT;
                    end
                end
                S_SQR: begin
                    if (step_last) begin
                        r_sq       <= n_r;
                        r_exp      <= r_exp >> 1;
                        r_left     <= r_left - LEFT_W'(1);
                        r_mul_done <= 1'b0;
                        r_state    <= S_NEXT;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_data  <= r_acc;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A delivered key is a proper residue whenever the modulus is nonzero.
    a_key_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_mod != '0) |-> (r_out_data < r_mod))
        else $error("key value not reduced below the modulus");

    // The partial remainder of the shared multiplier never leaves the residue range.
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED || r_state == S_MUL || r_state == S_SQR) |-> (r_r < r_mod))
        else $error("multiplier remainder out of range");

    // The accumulator fed to a multiply is already reduced.
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_a < r_mod))
        else $error("multiply operand not reduced");

    // An accepted beat always starts work, so no second beat can slip in.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("sequencer idle right after an accepted beat");

endmodule
